// ===== design/msu_pkg.sv =====
// Shared types and constants of the SIMD shift unit.
package msu_pkg;

  localparam int unsigned DW_BITS   = 64;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned HALF_BITS = 16;
  localparam int unsigned AMT_BITS  = 6;
  localparam int unsigned SA_BITS   = 8;

  // Instruction codes
  typedef enum logic [4:0] {
    OP_DSRA   = 5'd0,
    OP_DSLL   = 5'd1,
    OP_DSLL32 = 5'd2,
    OP_DSLLV  = 5'd3,
    OP_DSRA32 = 5'd4,
    OP_DSRAV  = 5'd5,
    OP_DSRL   = 5'd6,
    OP_DSRL32 = 5'd7,
    OP_DSRLV  = 5'd8,
    OP_SLL    = 5'd9,
    OP_SLLV   = 5'd10,
    OP_SRA    = 5'd11,
    OP_SRAV   = 5'd12,
    OP_SRL    = 5'd13,
    OP_SRLV   = 5'd14,
    OP_PSLLH  = 5'd15,
    OP_PSLLVW = 5'd16,
    OP_PSLLW  = 5'd17,
    OP_PSRAH  = 5'd18,
    OP_PSRAVW = 5'd19,
    OP_PSRAW  = 5'd20,
    OP_PSRLH  = 5'd21,
    OP_PSRLVW = 5'd22,
    OP_PSRLW  = 5'd23,
    OP_QFSRV  = 5'd24
  } op_t;

  // Shift direction of a lane
  typedef enum logic [1:0] {
    SH_LL = 2'd0,
    SH_RL = 2'd1,
    SH_RA = 2'd2
  } shift_kind_t;

  // Element layout of a lane
  typedef enum logic [2:0] {
    MODE_ZERO = 3'd0,
    MODE_D64  = 3'd1,
    MODE_W32X = 3'd2,
    MODE_P32  = 3'd3,
    MODE_P16  = 3'd4
  } lane_mode_t;

  typedef struct packed {
    lane_mode_t            mode;
    shift_kind_t           kind;
    logic [AMT_BITS-1:0]   amt;
  } lane_ctl_t;

  typedef struct packed {
    logic [4:0]          opcode;
    logic [4:0]          shift_field;
    logic [SA_BITS-1:0]  sa_amount;
    logic [DW_BITS-1:0]  rs_low;
    logic [DW_BITS-1:0]  rs_high;
    logic [DW_BITS-1:0]  rt_low;
    logic [DW_BITS-1:0]  rt_high;
  } in_t;

  typedef struct packed {
    logic [DW_BITS-1:0]  rd_low;
    logic [DW_BITS-1:0]  rd_high;
    logic                write_high;
  } out_t;

endpackage

// ===== design/msu_lane.sv =====
// One doubleword shift lane: 64-bit, sign-extended word, packed word or halfword.
module msu_lane
  import msu_pkg::*;
(
  input  logic [DW_BITS-1:0] data_in,
  input  lane_ctl_t          ctl,
  output logic [DW_BITS-1:0] data_out
);

  always_comb begin
    logic [WORD_BITS-1:0] w32;
    logic [WORD_BITS-1:0] r32;
    logic [HALF_BITS-1:0] h16;
    logic [HALF_BITS-1:0] r16;
    w32      = '0;
    r32      = '0;
    h16      = '0;
    r16      = '0;
    data_out = '0;
    unique case (ctl.mode)
      // Full doubleword shift
      MODE_D64: begin
        unique case (ctl.kind)
          SH_LL:   data_out = data_in << ctl.amt;
          SH_RL:   data_out = data_in >> ctl.amt;
          SH_RA:   data_out = DW_BITS'($signed(data_in) >>> ctl.amt);
          default: data_out = '0;
        endcase
      end
      // Low word shift, sign-extend the 32-bit result
      MODE_W32X: begin
        w32 = data_in[WORD_BITS-1:0];
        unique case (ctl.kind)
          SH_LL:   r32 = w32 << ctl.amt[4:0];
          SH_RL:   r32 = w32 >> ctl.amt[4:0];
          SH_RA:   r32 = WORD_BITS'($signed(w32) >>> ctl.amt[4:0]);
          default: r32 = '0;
        endcase
        data_out = {{WORD_BITS{r32[WORD_BITS-1]}}, r32};
      end
      // Two independent words
      MODE_P32: begin
        for (int i = 0; i < 2; i++) begin
          w32 = data_in[i*WORD_BITS +: WORD_BITS];
          unique case (ctl.kind)
            SH_LL:   r32 = w32 << ctl.amt[4:0];
            SH_RL:   r32 = w32 >> ctl.amt[4:0];
            SH_RA:   r32 = WORD_BITS'($signed(w32) >>> ctl.amt[4:0]);
            default: r32 = '0;
          endcase
          data_out[i*WORD_BITS +: WORD_BITS] = r32;
        end
      end
      // Four independent halfwords
      MODE_P16: begin
        for (int i = 0; i < 4; i++) begin
          h16 = data_in[i*HALF_BITS +: HALF_BITS];
          unique case (ctl.kind)
            SH_LL:   r16 = h16 << ctl.amt[3:0];
            SH_RL:   r16 = h16 >> ctl.amt[3:0];
            SH_RA:   r16 = HALF_BITS'($signed(h16) >>> ctl.amt[3:0]);
            default: r16 = '0;
          endcase
          data_out[i*HALF_BITS +: HALF_BITS] = r16;
        end
      end
      default: data_out = '0;
    endcase
  end

endmodule

// ===== design/msu_funnel.sv =====
// Funnel shift: {rs,rt} shifted right logically by the SA amount, low 128 bits kept.
module msu_funnel
  import msu_pkg::*;
(
  input  logic [DW_BITS-1:0]   rs_low,
  input  logic [DW_BITS-1:0]   rs_high,
  input  logic [DW_BITS-1:0]   rt_low,
  input  logic [DW_BITS-1:0]   rt_high,
  input  logic [SA_BITS-1:0]   sa,
  output logic [2*DW_BITS-1:0] result
);

  logic [4*DW_BITS-1:0] cat;
  logic [4*DW_BITS-1:0] shifted;

  // Concatenate with rs on top and shift as one 256-bit value
  assign cat     = {rs_high, rs_low, rt_high, rt_low};
  assign shifted = cat >> sa;
  assign result  = shifted[2*DW_BITS-1:0];

endmodule

// ===== design/mips64_simd_shift_unit.sv =====
// Top level of the SIMD shift unit: decode, two shift lanes, funnel and result merge.
//
// Usage:
//   Drive in_item and pulse start; a transaction is taken on every edge where start
//   is high and busy is low. busy is always low: the unit takes one instruction per
//   cycle, back to back, with no gaps.
//   The result appears on out_item in the cycle after the transaction is taken, marked
//   by out_valid for exactly that cycle. Throughput is 1 per cycle, set by the single
//   output register after the lane shifters.
//   The low and high doublewords are shifted by two identical lanes in parallel;
//   the funnel shifter runs beside them and the merge picks the result by opcode.
//   Scalar instructions leave rd_high at zero and write_high low. Unknown opcodes
//   give an all-zero result.
//   There is no result back-pressure: the receiver must take out_item whenever
//   out_valid is high.
//   Synchronous active-low reset clears out_valid; no instruction is in flight
//   after reset.
module mips64_simd_shift_unit
  import msu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  lane_ctl_t             ctl_lo;
  lane_ctl_t             ctl_hi;
  logic                  funnel_sel;
  logic                  wh;
  logic [DW_BITS-1:0]    lane_lo;
  logic [DW_BITS-1:0]    lane_hi;
  logic [2*DW_BITS-1:0]  funnel_res;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  out_t                  out_item_r;
  out_t                  out_item_nxt;
  logic [AMT_BITS-1:0]   imm6;
  logic [AMT_BITS-1:0]   imm32;
  logic [AMT_BITS-1:0]   var6;
  logic [AMT_BITS-1:0]   var_lo;
  logic [AMT_BITS-1:0]   var_hi;

  assign busy = 1'b0;

  // Shift amounts from the immediate and rs
  assign imm6   = {1'b0, in_item.shift_field};
  assign imm32  = {1'b1, in_item.shift_field};
  assign var6   = in_item.rs_low[AMT_BITS-1:0];
  assign var_lo = {1'b0, in_item.rs_low[4:0]};
  assign var_hi = {1'b0, in_item.rs_high[4:0]};

  // Decode the opcode into per-lane controls
  always_comb begin
    ctl_lo     = '{mode: MODE_ZERO, kind: SH_LL, amt: '0};
    ctl_hi     = '{mode: MODE_ZERO, kind: SH_LL, amt: '0};
    funnel_sel = 1'b0;
    wh         = 1'b0;
    unique case (in_item.opcode)
      OP_DSRA:   ctl_lo = '{mode: MODE_D64,  kind: SH_RA, amt: imm6};
      OP_DSLL:   ctl_lo = '{mode: MODE_D64,  kind: SH_LL, amt: imm6};
      OP_DSLL32: ctl_lo = '{mode: MODE_D64,  kind: SH_LL, amt: imm32};
      OP_DSLLV:  ctl_lo = '{mode: MODE_D64,  kind: SH_LL, amt: var6};
      OP_DSRA32: ctl_lo = '{mode: MODE_D64,  kind: SH_RA, amt: imm32};
      OP_DSRAV:  ctl_lo = '{mode: MODE_D64,  kind: SH_RA, amt: var6};
      OP_DSRL:   ctl_lo = '{mode: MODE_D64,  kind: SH_RL, amt: imm6};
      OP_DSRL32: ctl_lo = '{mode: MODE_D64,  kind: SH_RL, amt: imm32};
      OP_DSRLV:  ctl_lo = '{mode: MODE_D64,  kind: SH_RL, amt: var6};
      OP_SLL:    ctl_lo = '{mode: MODE_W32X, kind: SH_LL, amt: imm6};
      OP_SLLV:   ctl_lo = '{mode: MODE_W32X, kind: SH_LL, amt: var_lo};
      OP_SRA:    ctl_lo = '{mode: MODE_W32X, kind: SH_RA, amt: imm6};
      OP_SRAV:   ctl_lo = '{mode: MODE_W32X, kind: SH_RA, amt: var_lo};
      OP_SRL:    ctl_lo = '{mode: MODE_W32X, kind: SH_RL, amt: imm6};
      OP_SRLV:   ctl_lo = '{mode: MODE_W32X, kind: SH_RL, amt: var_lo};
      OP_PSLLH: begin
        ctl_lo = '{mode: MODE_P16, kind: SH_LL, amt: imm6};
        ctl_hi = ctl_lo;
        wh     = 1'b1;
      end
      OP_PSLLVW: begin
        ctl_lo = '{mode: MODE_W32X, kind: SH_LL, amt: var_lo};
        ctl_hi = '{mode: MODE_W32X, kind: SH_LL, amt: var_hi};
        wh     = 1'b1;
      end
      OP_PSLLW: begin
        ctl_lo = '{mode: MODE_P32, kind: SH_LL, amt: imm6};
        ctl_hi = ctl_lo;
        wh     = 1'b1;
      end
      OP_PSRAH: begin
        ctl_lo = '{mode: MODE_P16, kind: SH_RA, amt: imm6};
        ctl_hi = ctl_lo;
        wh     = 1'b1;
      end
      OP_PSRAVW: begin
        ctl_lo = '{mode: MODE_W32X, kind: SH_RA, amt: var_lo};
        ctl_hi = '{mode: MODE_W32X, kind: SH_RA, amt: var_hi};
        wh     = 1'b1;
      end
      OP_PSRAW: begin
        ctl_lo = '{mode: MODE_P32, kind: SH_RA, amt: imm6};
        ctl_hi = ctl_lo;
        wh     = 1'b1;
      end
      OP_PSRLH: begin
        ctl_lo = '{mode: MODE_P16, kind: SH_RL, amt: imm6};
        ctl_hi = ctl_lo;
        wh     = 1'b1;
      end
      OP_PSRLVW: begin
        ctl_lo = '{mode: MODE_W32X, kind: SH_RL, amt: var_lo};
        ctl_hi = '{mode: MODE_W32X, kind: SH_RL, amt: var_hi};
        wh     = 1'b1;
      end
      OP_PSRLW: begin
        ctl_lo = '{mode: MODE_P32, kind: SH_RL, amt: imm6};
        ctl_hi = ctl_lo;
        wh     = 1'b1;
      end
      OP_QFSRV: begin
        funnel_sel = 1'b1;
        wh         = 1'b1;
      end
      default: begin
        funnel_sel = 1'b0;
        wh         = 1'b0;
      end
    endcase
  end

  // Low and high doubleword lanes
  msu_lane u_lane_lo (
    .data_in  (in_item.rt_low),
    .ctl      (ctl_lo),
    .data_out (lane_lo)
  );

  msu_lane u_lane_hi (
    .data_in  (in_item.rt_high),
    .ctl      (ctl_hi),
    .data_out (lane_hi)
  );

  msu_funnel u_funnel (
    .rs_low  (in_item.rs_low),
    .rs_high (in_item.rs_high),
    .rt_low  (in_item.rt_low),
    .rt_high (in_item.rt_high),
    .sa      (in_item.sa_amount),
    .result  (funnel_res)
  );

  // Merge lane and funnel results
  always_comb begin
    out_valid_nxt = start & ~busy;
    out_item_nxt  = out_item_r;
    if (out_valid_nxt) begin
      if (funnel_sel) begin
        out_item_nxt.rd_low  = funnel_res[DW_BITS-1:0];
        out_item_nxt.rd_high = funnel_res[2*DW_BITS-1:DW_BITS];
      end else begin
        out_item_nxt.rd_low  = lane_lo;
        out_item_nxt.rd_high = lane_hi;
      end
      out_item_nxt.write_high = wh;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Every taken transaction yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("result strobe missing after accepted transaction");

  // No result without a transaction in the previous cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result strobe without transaction");

  // Scalar results leave the high doubleword clear
  a_scalar_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.write_high) |-> (out_item.rd_high == '0))
    else $error("scalar result with nonzero high doubleword");

  // write_high tracks the packed and funnel opcodes
  a_write_high_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_item.write_high ==
      (($past(in_item.opcode) >= OP_PSLLH) && ($past(in_item.opcode) <= OP_QFSRV))))
    else $error("write_high does not match opcode class");

endmodule

// ===== tb/mips64_simd_shift_unit_tb.sv =====
// Self-checking testbench of the SIMD shift unit: directed table, then random instructions.
module mips64_simd_shift_unit_tb
  import msu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes outside the instruction set
  localparam logic [4:0] OP_UNDEF_LO = 5'd25;
  localparam logic [4:0] OP_UNDEF_HI = 5'd31;

  localparam int unsigned RANDOM_INSTRS = 800;
  localparam int unsigned QUIET_FIRST   = 300;
  localparam int unsigned QUIET_LAST    = 500;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES  = 4;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DW_SIGN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] W_SIGNS  = 64'h8000_0000_8000_0000;

  typedef struct {
    in_t  item;
    bit   golden;
    out_t gold;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_item = '0;
  logic out_valid;
  out_t out_item;

  out_t      pending_results[$];
  stim_row_t directed[$];
  out_t      oldest;
  in_t       stim;
  int        n_errors = 0;
  int        quiet_cycles = 0;

  mips64_simd_shift_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] sext_word(logic [31:0] w);
    return {{32{w[31]}}, w};
  endfunction

  function automatic logic [63:0] sra_dw(logic [63:0] x, int unsigned n);
    logic signed [63:0] s;
    s = x;
    return s >>> n;
  endfunction

  // Shift every lane of width lane_w (16 or 32) in one doubleword
  function automatic logic [63:0] lane_shift(logic [63:0] x, int unsigned n,
                                             int unsigned lane_w, shift_kind_t kind);
    logic [63:0] mask, e, v, r;
    mask = (lane_w == WORD_BITS) ? 64'hFFFF_FFFF : 64'hFFFF;
    r = '0;
    for (int unsigned pos = 0; pos < DW_BITS; pos += lane_w) begin
      e = (x >> pos) & mask;
      case (kind)
        SH_LL: v = (e << n) & mask;
        SH_RL: v = e >> n;
        default: begin
          v = (lane_w == WORD_BITS) ? sext_word(e[31:0]) : {{48{e[15]}}, e[15:0]};
          v = sra_dw(v, n) & mask;
        end
      endcase
      r |= v << pos;
    end
    return r;
  endfunction

  // Compute the result of one shift instruction
  function automatic out_t predict_shift(in_t it);
    out_t          r;
    int unsigned   imm, v6, v5, h4, a0, a1;
    logic [255:0]  funnel;
    imm = 32'(it.shift_field);
    v6  = 32'(it.rs_low[5:0]);
    v5  = 32'(it.rs_low[4:0]);
    h4  = 32'(it.shift_field[3:0]);
    a0  = 32'(it.rs_low[4:0]);
    a1  = 32'(it.rs_high[4:0]);
    r = '0;
    case (it.opcode)
      OP_DSRA:   r.rd_low = sra_dw(it.rt_low, imm);
      OP_DSLL:   r.rd_low = it.rt_low << imm;
      OP_DSLL32: r.rd_low = it.rt_low << (imm + WORD_BITS);
      OP_DSLLV:  r.rd_low = it.rt_low << v6;
      OP_DSRA32: r.rd_low = sra_dw(it.rt_low, imm + WORD_BITS);
      OP_DSRAV:  r.rd_low = sra_dw(it.rt_low, v6);
      OP_DSRL:   r.rd_low = it.rt_low >> imm;
      OP_DSRL32: r.rd_low = it.rt_low >> (imm + WORD_BITS);
      OP_DSRLV:  r.rd_low = it.rt_low >> v6;
      OP_SLL:    r.rd_low = sext_word(it.rt_low[31:0] << imm);
      OP_SLLV:   r.rd_low = sext_word(it.rt_low[31:0] << v5);
      OP_SRA:    r.rd_low = sra_dw(sext_word(it.rt_low[31:0]), imm);
      OP_SRAV:   r.rd_low = sra_dw(sext_word(it.rt_low[31:0]), v5);
      OP_SRL:    r.rd_low = sext_word(it.rt_low[31:0] >> imm);
      OP_SRLV:   r.rd_low = sext_word(it.rt_low[31:0] >> v5);
      OP_PSLLH: begin
        r.rd_low  = lane_shift(it.rt_low, h4, HALF_BITS, SH_LL);
        r.rd_high = lane_shift(it.rt_high, h4, HALF_BITS, SH_LL);
      end
      OP_PSLLVW: begin
        r.rd_low  = sext_word(it.rt_low[31:0] << a0);
        r.rd_high = sext_word(it.rt_high[31:0] << a1);
      end
      OP_PSLLW: begin
        r.rd_low  = lane_shift(it.rt_low, imm, WORD_BITS, SH_LL);
        r.rd_high = lane_shift(it.rt_high, imm, WORD_BITS, SH_LL);
      end
      OP_PSRAH: begin
        r.rd_low  = lane_shift(it.rt_low, h4, HALF_BITS, SH_RA);
        r.rd_high = lane_shift(it.rt_high, h4, HALF_BITS, SH_RA);
      end
      OP_PSRAVW: begin
        r.rd_low  = sra_dw(sext_word(it.rt_low[31:0]), a0);
        r.rd_high = sra_dw(sext_word(it.rt_high[31:0]), a1);
      end
      OP_PSRAW: begin
        r.rd_low  = lane_shift(it.rt_low, imm, WORD_BITS, SH_RA);
        r.rd_high = lane_shift(it.rt_high, imm, WORD_BITS, SH_RA);
      end
      OP_PSRLH: begin
        r.rd_low  = lane_shift(it.rt_low, h4, HALF_BITS, SH_RL);
        r.rd_high = lane_shift(it.rt_high, h4, HALF_BITS, SH_RL);
      end
      OP_PSRLVW: begin
        r.rd_low  = sext_word(it.rt_low[31:0] >> a0);
        r.rd_high = sext_word(it.rt_high[31:0] >> a1);
      end
      OP_PSRLW: begin
        r.rd_low  = lane_shift(it.rt_low, imm, WORD_BITS, SH_RL);
        r.rd_high = lane_shift(it.rt_high, imm, WORD_BITS, SH_RL);
      end
      OP_QFSRV: begin
        // rs forms the upper half of the 256-bit funnel
        funnel    = {it.rs_high, it.rs_low, it.rt_high, it.rt_low} >> it.sa_amount;
        r.rd_low  = funnel[63:0];
        r.rd_high = funnel[127:64];
      end
      default: r = '0;
    endcase
    // Packed ops and the funnel write the high doubleword
    r.write_high = (it.opcode >= OP_PSLLH && it.opcode <= OP_QFSRV);
    return r;
  endfunction

  // Bias doublewords toward zero, all ones and lane sign bits
  function automatic logic [63:0] rand_dw();
    case ($urandom_range(7))
      0: return '0;
      1: return ALL_ONES;
      2: return DW_SIGN;
      3: return W_SIGNS;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_t rand_instr();
    in_t it;
    it.opcode      = ($urandom_range(15) == 0) ? 5'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO))
                                               : 5'($urandom_range(OP_QFSRV, OP_DSRA));
    it.shift_field = 5'($urandom);
    it.sa_amount   = ($urandom_range(3) == 0) ? {2'($urandom_range(3)), 6'd0}
                                              : 8'($urandom);
    it.rs_low      = rand_dw();
    it.rs_high     = rand_dw();
    it.rt_low      = rand_dw();
    it.rt_high     = rand_dw();
    return it;
  endfunction

  task automatic add_row(input logic [4:0] op, input logic [4:0] imm, input logic [7:0] sa,
                         input logic [63:0] rsl, input logic [63:0] rsh,
                         input logic [63:0] rtl, input logic [63:0] rth,
                         input bit golden, input logic [63:0] lo = '0,
                         input logic [63:0] hi = '0, input logic wh = 1'b0);
    stim_row_t row;
    row.item   = '{op, imm, sa, rsl, rsh, rtl, rth};
    row.golden = golden;
    row.gold   = '{lo, hi, wh};
    directed.push_back(row);
  endtask

  // Offer one transaction, idle first at random, hold until taken
  task automatic issue(input in_t item, input out_t want, input bit may_idle);
    while (may_idle && $urandom_range(99) < 37) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(want);
  endtask

  // Check each result against the oldest expectation; watch for a stall
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_item);
        n_errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_item.rd_low !== oldest.rd_low) begin
          $display("%0t: rd_low expected %h actual %h", $time, oldest.rd_low, out_item.rd_low);
          n_errors++;
        end
        if (out_item.rd_high !== oldest.rd_high) begin
          $display("%0t: rd_high expected %h actual %h", $time, oldest.rd_high,
                   out_item.rd_high);
          n_errors++;
        end
        if (out_item.write_high !== oldest.write_high) begin
          $display("%0t: write_high expected %b actual %b", $time, oldest.write_high,
                   out_item.write_high);
          n_errors++;
        end
      end
    end
  end

  initial begin
    // Directed rows: extremes, every opcode but DSRL and SRLV, sign extension and funnel limbs
    add_row(OP_DSRA,   5'd31, 8'd0, '0, '0, DW_SIGN, '0, 1'b0);
    add_row(OP_DSLL,   5'd0,  8'd0, '0, '0, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES);
    add_row(OP_DSLL32, 5'd31, 8'd0, '0, '0, 64'd1, '0, 1'b1, DW_SIGN);
    add_row(OP_DSLLV,  5'd0,  8'd0, ALL_ONES, '0, 64'h0123_4567_89AB_CDEF, '0, 1'b0);
    add_row(OP_DSRA32, 5'd31, 8'd0, '0, '0, DW_SIGN, '0, 1'b1, ALL_ONES);
    add_row(OP_DSRAV,  5'd0,  8'd0, ALL_ONES, '0, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b0);
    add_row(OP_DSRL32, 5'd31, 8'd0, '0, '0, ALL_ONES, '0, 1'b1, 64'd1);
    add_row(OP_DSRLV,  5'd7,  8'd0, 64'hFFFF_FFFF_FFFF_FFC0, '0, W_SIGNS, '0, 1'b0);
    add_row(OP_SLL,    5'd31, 8'd0, '0, '0, 64'd1, '0, 1'b1, 64'hFFFF_FFFF_8000_0000);
    add_row(OP_SLLV,   5'd3,  8'd0, 64'h20, '0, 64'hFFFF_FFFF_7FFF_FFFF, '0, 1'b0);
    add_row(OP_SRA,    5'd31, 8'd0, '0, '0, 64'h8000_0000, '0, 1'b1, ALL_ONES);
    add_row(OP_SRAV,   5'd0,  8'd0, 64'h1F, ALL_ONES, 64'h1234_5678_9ABC_DEF0, '0, 1'b0);
    add_row(OP_SRL,    5'd0,  8'd0, '0, '0, 64'h8000_0000, '0, 1'b1,
            64'hFFFF_FFFF_8000_0000);
    add_row(OP_PSLLH,  5'd31, 8'd0, '0, '0, ALL_ONES, 64'h8001_4002_2004_1008, 1'b0);
    add_row(OP_PSLLVW, 5'd0,  8'd0, 64'h1F, '0, ALL_ONES, 64'h0000_0001_0000_0001, 1'b0);
    add_row(OP_PSLLW,  5'd31, 8'd0, '0, '0, W_SIGNS, 64'h0000_0001_0000_0003, 1'b0);
    add_row(OP_PSRAH,  5'd16, 8'd0, '0, '0, 64'h8000_7FFF_8000_7FFF, ALL_ONES, 1'b0);
    add_row(OP_PSRAVW, 5'd0,  8'd0, 64'h1F, 64'h1F, W_SIGNS, 64'h7FFF_FFFF_7FFF_FFFF, 1'b0);
    add_row(OP_PSRAW,  5'd31, 8'd0, '0, '0, W_SIGNS, 64'h4000_0000_C000_0000, 1'b0);
    add_row(OP_PSRLH,  5'd15, 8'd0, '0, '0, ALL_ONES, 64'h8000_8000_0001_0001, 1'b0);
    add_row(OP_PSRLVW, 5'd0,  8'd0, '0, '0, W_SIGNS, W_SIGNS, 1'b0);
    add_row(OP_PSRLW,  5'd31, 8'd0, '0, '0, ALL_ONES, W_SIGNS, 1'b0);
    add_row(OP_QFSRV,  5'd0,  8'd0, ALL_ONES, ALL_ONES, 64'h0123_4567_89AB_CDEF,
            64'hFEDC_BA98_7654_3210, 1'b1, 64'h0123_4567_89AB_CDEF,
            64'hFEDC_BA98_7654_3210, 1'b1);
    add_row(OP_QFSRV,  5'd0,  8'd128, 64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888,
            ALL_ONES, ALL_ONES, 1'b1, 64'h1111_2222_3333_4444,
            64'h5555_6666_7777_8888, 1'b1);
    add_row(OP_QFSRV,  5'd0,  8'd255, '0, DW_SIGN, '0, '0, 1'b1, 64'd1, '0, 1'b1);
    add_row(OP_QFSRV,  5'd0,  8'd100, 64'hA5A5_A5A5_5A5A_5A5A, ALL_ONES, DW_SIGN,
            64'h0F0F_0F0F_F0F0_F0F0, 1'b0);
    add_row(OP_UNDEF_LO, 5'd31, 8'd255, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1);
    add_row(OP_UNDEF_HI, 5'd31, 8'd255, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1);

    // Hold reset, then release
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      issue(directed[i].item,
            directed[i].golden ? directed[i].gold : predict_shift(directed[i].item), 1'b1);
    end

    // Random instructions with a stretch of back-to-back issue
    for (int unsigned k = 0; k < RANDOM_INSTRS; k++) begin
      stim = rand_instr();
      issue(stim, predict_shift(stim), !(k >= QUIET_FIRST && k < QUIET_LAST));
    end
    start <= 1'b0;

    // Drain outstanding results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
